>>> rtl/core/blfd_pkg.sv
// Shared types, constants and the CRC byte update for the binary log frame deframer.
// No dependencies; imported by binary_log_frame_deframer.
package blfd_pkg;

	// Header length, sync bytes included
	localparam int HEADER_BYTES = 28;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 32;

	// Configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_SYNC_PATTERN    = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_CRC_POLYNOMIAL  = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_MAX_BODY_LENGTH = 2'd2;

	localparam logic [23:0] SYNC_PATTERN_RST    = 24'hAA4412;
	localparam logic [31:0] CRC_POLYNOMIAL_RST  = 32'hEDB88320;
	localparam logic [15:0] MAX_BODY_LENGTH_RST = 16'd4096;

	// Header byte positions, counted from the first sync byte
	localparam logic [15:0] POS_SYNC_DONE = 16'd3;
	localparam logic [15:0] POS_ID_LO     = 16'd4;
	localparam logic [15:0] POS_ID_HI     = 16'd5;
	localparam logic [15:0] POS_TYPE      = 16'd6;
	localparam logic [15:0] POS_LEN_LO    = 16'd8;
	localparam logic [15:0] POS_LEN_HI    = 16'd9;
	localparam logic [15:0] POS_WEEK_LO   = 16'd14;
	localparam logic [15:0] POS_WEEK_HI   = 16'd15;
	localparam logic [15:0] POS_MS_FIRST  = 16'd16;
	localparam logic [15:0] POS_MS_LAST   = 16'd19;

	// Record kinds
	localparam logic [1:0] KIND_BODY      = 2'd0;
	localparam logic [1:0] KIND_GOOD      = 2'd1;
	localparam logic [1:0] KIND_CRC_BAD   = 2'd2;
	localparam logic [1:0] KIND_TOO_LONG  = 2'd3;

	typedef enum logic [3:0] {
		PH_HUNT   = 4'b0001,
		PH_HEADER = 4'b0010,
		PH_BODY   = 4'b0100,
		PH_CRC    = 4'b1000
	} phase_t;

	typedef struct packed {
		logic [1:0]  record_kind;
		logic [7:0]  body_byte;
		logic [15:0] body_offset;
		logic [15:0] message_id;
		logic [1:0]  message_format;
		logic [15:0] body_length;
		logic [15:0] gps_week;
		logic [31:0] week_milliseconds;
	} record_t;

	// One byte of a reflected CRC, unrolled over eight bit steps
	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data,
		input logic [31:0] poly);
		logic [31:0] c;
		c = crc ^ {24'd0, data};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
		end
		return c;
	endfunction

endpackage

>>> rtl/core/binary_log_frame_deframer.sv
// Binary log frame deframer: sync hunt, header capture, body pass-through, CRC-32 check.
// Single module; depends on blfd_pkg for types, constants and the CRC byte update.
//
// Usage:
//   Input channel (in_valid / in_stall / data_byte) carries one stream byte per beat.
//   Output channel (out_valid / out_stall / record fields) carries one record per beat:
//   a body byte with its offset, or a frame-end record (good, CRC mismatch, too long).
//   Header fields of the current frame ride along with every record.
//   Records are built from the input register into the output or skid register.
//   Throughput: one byte per cycle unless a stall or rebuild holds it off; the CRC
//   byte update, from input register to running CRC register, sets the cycle time.
//   A write to crc_polynomial holds off byte processing (in_stall rises if a byte waits)
//   while rebuild1 and rebuild2 rebuild the sync window CRCs with the new polynomial.
//   Stall: the output register has a one-beat skid stage behind it, so in_stall is
//   driven from registers only; it rises once the skid stage fills while a byte waits.
//   Reset: asynchronous, active low; registers return to their reset values, the
//   sync window empties and the parser hunts for sync. Config writes (cfg_write,
//   cfg_index, cfg_data) take effect at the edge; indexes past the last are dropped.
module binary_log_frame_deframer (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_write,
	input  logic [blfd_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [blfd_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [7:0]                         data_byte,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [1:0]                         record_kind,
	output logic [7:0]                         body_byte,
	output logic [15:0]                        body_offset,
	output logic [15:0]                        message_id,
	output logic [1:0]                         message_format,
	output logic [15:0]                        body_length,
	output logic [15:0]                        gps_week,
	output logic [31:0]                        week_milliseconds
);
	import blfd_pkg::*;

	// Configuration registers
	logic [23:0] sync_pattern_q;
	logic [31:0] crc_poly_q;
	logic [15:0] max_len_q;

	// Input register
	logic        valid_s1;
	logic [7:0]  byte_s1;

	// Parser state
	phase_t      phase_q, phase_d;
	logic [15:0] window_q, window_d;
	logic [31:0] win_crc1_q, win_crc1_d;   // CRC from zero over the newest window byte
	logic [31:0] win_crc2_q, win_crc2_d;   // CRC from zero over both window bytes
	logic [15:0] count_q, count_d;
	logic [31:0] run_crc_q, run_crc_d;
	logic [31:0] rx_crc_q, rx_crc_d;
	logic [15:0] id_q, id_d;
	logic [1:0]  fmt_q, fmt_d;
	logic [15:0] len_q, len_d;
	logic [15:0] week_q, week_d;
	logic [31:0] ms_q, ms_d;

	// Window CRC rebuild after a polynomial write
	logic        rebuild1_q, rebuild2_q;
	logic [31:0] hi_crc_q;
	logic        rebuild_busy;

	// Output register and skid stage
	record_t     out_q, skid_q, res;
	logic        out_valid_q, skid_valid_q;
	logic        res_valid;

	logic        proc;
	logic        accept;
	logic        take;
	logic [16:0] count_inc;
	logic [31:0] crc_next;

	assign rebuild_busy = rebuild1_q | rebuild2_q;
	assign proc         = valid_s1 & ~skid_valid_q & ~rebuild_busy;
	assign in_stall     = valid_s1 & (skid_valid_q | rebuild_busy);
	assign accept       = in_valid & ~in_stall;
	assign take         = out_valid_q & ~out_stall;
	assign count_inc    = {1'b0, count_q} + 17'd1;
	assign crc_next     = crc_byte(run_crc_q, byte_s1, crc_poly_q);

	// Parser next state and result for the byte in the input register
	always_comb begin
		phase_d    = phase_q;
		window_d   = window_q;
		win_crc1_d = win_crc1_q;
		win_crc2_d = win_crc2_q;
		count_d    = count_q;
		run_crc_d  = run_crc_q;
		rx_crc_d   = rx_crc_q;
		id_d       = id_q;
		fmt_d      = fmt_q;
		len_d      = len_q;
		week_d     = week_q;
		ms_d       = ms_q;
		res_valid  = 1'b0;
		res.record_kind       = KIND_BODY;
		res.body_byte         = 8'd0;
		res.body_offset       = 16'd0;

		case (phase_q)
			PH_HUNT: begin
				if ({window_q, byte_s1} == sync_pattern_q) begin
					// Window bytes equal the first two sync bytes here
					run_crc_d  = crc_byte(win_crc2_q, byte_s1, crc_poly_q);
					id_d       = 16'd0;
					fmt_d      = 2'd0;
					len_d      = 16'd0;
					week_d     = 16'd0;
					ms_d       = 32'd0;
					rx_crc_d   = 32'd0;
					window_d   = 16'd0;
					win_crc1_d = 32'd0;
					win_crc2_d = 32'd0;
					count_d    = POS_SYNC_DONE;
					phase_d    = PH_HEADER;
				end else begin
					window_d   = {window_q[7:0], byte_s1};
					win_crc1_d = crc_byte(32'd0, byte_s1, crc_poly_q);
					win_crc2_d = crc_byte(win_crc1_q, byte_s1, crc_poly_q);
				end
			end
			PH_HEADER: begin
				run_crc_d = crc_next;
				if (count_q == POS_ID_LO) id_d[7:0] = byte_s1;
				else if (count_q == POS_ID_HI) id_d[15:8] = byte_s1;
				else if (count_q == POS_TYPE) fmt_d = byte_s1[5:4];
				else if (count_q == POS_LEN_LO) len_d[7:0] = byte_s1;
				else if (count_q == POS_LEN_HI) len_d[15:8] = byte_s1;
				else if (count_q == POS_WEEK_LO) week_d[7:0] = byte_s1;
				else if (count_q == POS_WEEK_HI) week_d[15:8] = byte_s1;
				else if (count_q >= POS_MS_FIRST && count_q <= POS_MS_LAST) begin
					case (count_q[1:0])
						2'd0:    ms_d[7:0]   = ms_q[7:0]   | byte_s1;
						2'd1:    ms_d[15:8]  = ms_q[15:8]  | byte_s1;
						2'd2:    ms_d[23:16] = ms_q[23:16] | byte_s1;
						default: ms_d[31:24] = ms_q[31:24] | byte_s1;
					endcase
				end
				count_d = count_inc[15:0];
				if (count_inc >= 17'(HEADER_BYTES)) begin
					// Last header byte never touches the length field
					if (len_q > max_len_q) begin
						res_valid       = 1'b1;
						res.record_kind = KIND_TOO_LONG;
						phase_d         = PH_HUNT;
						window_d        = 16'd0;
						win_crc1_d      = 32'd0;
						win_crc2_d      = 32'd0;
						count_d         = 16'd0;
					end else begin
						count_d = 16'd0;
						phase_d = (len_q == 16'd0) ? PH_CRC : PH_BODY;
					end
				end
			end
			PH_BODY: begin
				run_crc_d       = crc_next;
				res_valid       = 1'b1;
				res.record_kind = KIND_BODY;
				res.body_byte   = byte_s1;
				res.body_offset = count_q;
				count_d         = count_inc[15:0];
				if (count_inc >= {1'b0, len_q}) begin
					count_d = 16'd0;
					phase_d = PH_CRC;
				end
			end
			PH_CRC: begin
				case (count_q[1:0])
					2'd0:    rx_crc_d[7:0]   = rx_crc_q[7:0]   | byte_s1;
					2'd1:    rx_crc_d[15:8]  = rx_crc_q[15:8]  | byte_s1;
					2'd2:    rx_crc_d[23:16] = rx_crc_q[23:16] | byte_s1;
					default: rx_crc_d[31:24] = rx_crc_q[31:24] | byte_s1;
				endcase
				count_d = {14'd0, count_q[1:0]} + 16'd1;
				if (count_q[1:0] == 2'd3) begin
					res_valid       = 1'b1;
					res.record_kind = (rx_crc_d == run_crc_q) ? KIND_GOOD : KIND_CRC_BAD;
					phase_d         = PH_HUNT;
					window_d        = 16'd0;
					win_crc1_d      = 32'd0;
					win_crc2_d      = 32'd0;
					count_d         = 16'd0;
				end
			end
			default: begin
				phase_d = PH_HUNT;
			end
		endcase

		// Header fields as they stand after this byte
		res.message_id        = id_d;
		res.message_format    = fmt_d;
		res.body_length       = len_d;
		res.gps_week          = week_d;
		res.week_milliseconds = ms_d;
	end

	// Configuration registers and window CRC rebuild
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_pattern_q <= SYNC_PATTERN_RST;
			crc_poly_q     <= CRC_POLYNOMIAL_RST;
			max_len_q      <= MAX_BODY_LENGTH_RST;
			rebuild1_q     <= 1'b0;
			rebuild2_q     <= 1'b0;
		end else begin
			rebuild2_q <= rebuild1_q;
			rebuild1_q <= 1'b0;
			if (cfg_write) begin
				case (cfg_index)
					CFG_SYNC_PATTERN:    sync_pattern_q <= cfg_data[23:0];
					CFG_CRC_POLYNOMIAL: begin
						crc_poly_q <= cfg_data;
						rebuild1_q <= 1'b1;
					end
					CFG_MAX_BODY_LENGTH: max_len_q <= cfg_data[15:0];
					default: ;
				endcase
			end
		end
	end

	// Partial CRC of the older window byte during a rebuild
	always_ff @(posedge clk) begin
		if (rebuild1_q) begin
			hi_crc_q <= crc_byte(32'd0, window_q[15:8], crc_poly_q);
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (proc) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= data_byte;
		end
	end

	// Parser state; rebuild the window CRCs while byte processing is held off
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HUNT;
			window_q   <= 16'd0;
			win_crc1_q <= 32'd0;
			win_crc2_q <= 32'd0;
			count_q    <= 16'd0;
			run_crc_q  <= 32'd0;
			rx_crc_q   <= 32'd0;
			id_q       <= 16'd0;
			fmt_q      <= 2'd0;
			len_q      <= 16'd0;
			week_q     <= 16'd0;
			ms_q       <= 32'd0;
		end else if (rebuild1_q) begin
			win_crc1_q <= crc_byte(32'd0, window_q[7:0], crc_poly_q);
		end else if (rebuild2_q) begin
			win_crc2_q <= crc_byte(hi_crc_q, window_q[7:0], crc_poly_q);
		end else if (proc) begin
			phase_q    <= phase_d;
			window_q   <= window_d;
			win_crc1_q <= win_crc1_d;
			win_crc2_q <= win_crc2_d;
			count_q    <= count_d;
			run_crc_q  <= run_crc_d;
			rx_crc_q   <= rx_crc_d;
			id_q       <= id_d;
			fmt_q      <= fmt_d;
			len_q      <= len_d;
			week_q     <= week_d;
			ms_q       <= ms_d;
		end
	end

	// Output register with skid stage: drain skid first, park a new record in skid
	// when the output register is held
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (!out_valid_q || take) begin
				if (skid_valid_q) begin
					out_valid_q  <= 1'b1;
					skid_valid_q <= 1'b0;
				end else begin
					out_valid_q <= proc & res_valid;
				end
			end else if (proc && res_valid) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || take) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (proc && res_valid) begin
				out_q <= res;
			end
		end else if (proc && res_valid) begin
			skid_q <= res;
		end
	end

	assign out_valid         = out_valid_q;
	assign record_kind       = out_q.record_kind;
	assign body_byte         = out_q.body_byte;
	assign body_offset       = out_q.body_offset;
	assign message_id        = out_q.message_id;
	assign message_format    = out_q.message_format;
	assign body_length       = out_q.body_length;
	assign gps_week          = out_q.gps_week;
	assign week_milliseconds = out_q.week_milliseconds;

endmodule
